// File: src/tfb_pkg.sv
// Shared types, constants and the CRC byte update for the telemetry frame builder.
// Used by the byte emitter and the top level.
package tfb_pkg;

   localparam logic [7:0] MAGIC_LO = 8'hA5;
   localparam logic [7:0] MAGIC_HI = 8'h5A;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_MSB = 16'h8000;
   localparam logic [7:0] RST_FORMAT_VERSION = 8'h01;
   localparam logic [7:0] RST_MESSAGE_TYPE = 8'h02;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_FORMAT_VERSION = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_MESSAGE_TYPE = 1'b1;

   typedef logic [3:0] slot_type;

   localparam slot_type SLOT_MAGIC_LO = 4'd0;
   localparam slot_type SLOT_MAGIC_HI = 4'd1;
   localparam slot_type SLOT_VERSION = 4'd2;
   localparam slot_type SLOT_MESSAGE_TYPE = 4'd3;
   localparam slot_type SLOT_LEN_LO = 4'd4;
   localparam slot_type SLOT_LEN_HI = 4'd5;
   localparam slot_type SLOT_SEQ_LO = 4'd6;
   localparam slot_type SLOT_SEQ_HI = 4'd7;
   localparam slot_type SLOT_TS_B0 = 4'd8;
   localparam slot_type SLOT_TS_B1 = 4'd9;
   localparam slot_type SLOT_TS_B2 = 4'd10;
   localparam slot_type SLOT_TS_B3 = 4'd11;
   localparam slot_type SLOT_PAYLOAD = 4'd12;
   localparam slot_type SLOT_CRC_LO = 4'd13;
   localparam slot_type SLOT_CRC_HI = 4'd14;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [31:0] stamp_ms;
      logic [15:0] seq_number;
      logic [7:0] format_version;
      logic [7:0] message_type;
      slot_type first_slot;
      slot_type last_slot;
   } item_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 16'h0000) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

// File: src/tfb_req_if.sv
// Input channel: one payload byte and a timestamp per transaction.
// Standalone interface; no package dependency.
interface tfb_req_if;
   logic valid;
   logic ready;
   logic [7:0] payload_byte;
   logic [31:0] stamp_ms;

   modport source (output valid, output payload_byte, output stamp_ms, input ready);
   modport sink (input valid, input payload_byte, input stamp_ms, output ready);
endinterface

// File: src/tfb_rsp_if.sv
// Result channel: one frame byte with its run and frame markers per transaction.
// Standalone interface; no package dependency.
interface tfb_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] frame_byte;
   logic last_of_run;
   logic last_of_frame;

   modport source (output valid, output frame_byte, output last_of_run, output last_of_frame,
                   input ready);
   modport sink (input valid, input frame_byte, input last_of_run, input last_of_frame,
                 output ready);
endinterface

// File: src/telemetry_frame_builder_crc16_top.sv
// Each accepted transaction loads the emitter's single byte slot walker, which registers
// its results onto the result channel. Throughput: one result per cycle unless that
// channel stalls. A middle payload byte emits alone, a first byte follows the header,
// a last byte precedes the CRC; a one-byte payload's CRC goes out on the next request.
// Reset is synchronous: the frame position, sequence number, and pending CRC clear,
// the CRC reloads FFFF and the registers return to version 1 and message type 2.
module telemetry_frame_builder_crc16_top #(
   parameter int PAYLOAD_BYTES = 134
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [tfb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0] csr_write_data,
   tfb_req_if.sink req_bus,
   tfb_rsp_if.source rsp_bus
);
   import tfb_pkg::*;

   localparam int POS_W = $clog2((PAYLOAD_BYTES > 1) ? PAYLOAD_BYTES : 2);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(PAYLOAD_BYTES - 1);

   logic [7:0] version_ff;
   logic [7:0] message_type_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0] seq_ff, seq_in;
   logic pending_ff, pending_in;

   logic accept, load_ready;
   item_type item;

   assign req_bus.ready = load_ready;
   assign accept = req_bus.valid && load_ready;

   always_comb begin
      item.payload_byte = req_bus.payload_byte;
      item.stamp_ms = req_bus.stamp_ms;
      item.seq_number = seq_ff;
      item.format_version = version_ff;
      item.message_type = message_type_ff;
      if (pending_ff) begin
         item.first_slot = SLOT_CRC_LO;
         item.last_slot = SLOT_CRC_HI;
      end else if (pos_ff == '0) begin
         item.first_slot = SLOT_MAGIC_LO;
         item.last_slot = SLOT_PAYLOAD;
      end else if (pos_ff == POS_LAST) begin
         item.first_slot = SLOT_PAYLOAD;
         item.last_slot = SLOT_CRC_HI;
      end else begin
         item.first_slot = SLOT_PAYLOAD;
         item.last_slot = SLOT_PAYLOAD;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      seq_in = seq_ff;
      pending_in = pending_ff;
      if (accept) begin
         if (pending_ff) begin
            pending_in = 1'b0;
            pos_in = '0;
         end else begin
            if (pos_ff == '0) begin
               seq_in = seq_ff + 16'd1;
            end
            if (pos_ff == POS_LAST) begin
               pos_in = '0;
               pending_in = (pos_ff == '0);
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= RST_FORMAT_VERSION;
         message_type_ff <= RST_MESSAGE_TYPE;
         pos_ff <= '0;
         seq_ff <= 16'h0000;
         pending_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         seq_ff <= seq_in;
         pending_ff <= pending_in;
         if (csr_write_enable) begin
            case (csr_index)
               REG_FORMAT_VERSION: version_ff <= csr_write_data;
               REG_MESSAGE_TYPE:   message_type_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   tfb_emitter #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) u_emitter (
      .clock(clock),
      .reset(reset),
      .load(accept),
      .item(item),
      .load_ready(load_ready),
      .rsp(rsp_bus)
   );

endmodule

// File: src/tfb_emitter.sv
// Byte emitter: holds one accepted item, walks its frame slots one byte per cycle unless
// rsp stalls, keeps the running CRC, drives the registered rsp channel; uses tfb_pkg.
module tfb_emitter #(
   parameter int PAYLOAD_BYTES = 134
) (
   input  logic clock,
   input  logic reset,
   input  logic load,
   input  tfb_pkg::item_type item,
   output logic load_ready,
   tfb_rsp_if.source rsp
);
   import tfb_pkg::*;

   localparam logic [15:0] FRAME_LEN = 16'(PAYLOAD_BYTES);

   item_type item_ff;
   logic busy_ff, busy_in;
   slot_type slot_ff, slot_in;
   logic [15:0] crc_ff;
   logic rsp_valid_ff;
   logic [7:0] byte_ff;
   logic run_end_ff;
   logic frame_end_ff;

   logic out_free, fire, done;
   logic [7:0] cur_byte;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign fire = busy_ff && out_free;
   assign done = fire && (slot_ff == item_ff.last_slot);
   assign load_ready = !busy_ff || done;

   always_comb begin
      case (slot_ff)
         SLOT_MAGIC_LO: cur_byte = MAGIC_LO;
         SLOT_MAGIC_HI: cur_byte = MAGIC_HI;
         SLOT_VERSION:  cur_byte = item_ff.format_version;
         SLOT_MESSAGE_TYPE: cur_byte = item_ff.message_type;
         SLOT_LEN_LO:   cur_byte = FRAME_LEN[7:0];
         SLOT_LEN_HI:   cur_byte = FRAME_LEN[15:8];
         SLOT_SEQ_LO:   cur_byte = item_ff.seq_number[7:0];
         SLOT_SEQ_HI:   cur_byte = item_ff.seq_number[15:8];
         SLOT_TS_B0:    cur_byte = item_ff.stamp_ms[7:0];
         SLOT_TS_B1:    cur_byte = item_ff.stamp_ms[15:8];
         SLOT_TS_B2:    cur_byte = item_ff.stamp_ms[23:16];
         SLOT_TS_B3:    cur_byte = item_ff.stamp_ms[31:24];
         SLOT_PAYLOAD:  cur_byte = item_ff.payload_byte;
         SLOT_CRC_LO:   cur_byte = crc_ff[7:0];
         SLOT_CRC_HI:   cur_byte = crc_ff[15:8];
         default:       cur_byte = 8'h00;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      slot_in = slot_ff;
      if (load) begin
         busy_in = 1'b1;
         slot_in = item.first_slot;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (fire) begin
         slot_in = slot_ff + slot_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         slot_ff <= SLOT_MAGIC_LO;
         crc_ff <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         slot_ff <= slot_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            if (slot_ff <= SLOT_PAYLOAD) begin
               crc_ff <= crc16_byte((slot_ff == SLOT_MAGIC_LO) ? CRC_INIT : crc_ff, cur_byte);
            end else if (slot_ff == SLOT_CRC_HI) begin
               crc_ff <= CRC_INIT;
            end
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
      if (fire) begin
         byte_ff <= cur_byte;
         run_end_ff <= (slot_ff == item_ff.last_slot);
         frame_end_ff <= (slot_ff == SLOT_CRC_HI);
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.frame_byte = byte_ff;
   assign rsp.last_of_run = run_end_ff;
   assign rsp.last_of_frame = frame_end_ff;

endmodule
